@@ rtl/tlbp_pkg.sv @@
`default_nettype none

package tlbp_pkg;

  // Field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned HIST_W    = 10;
  localparam int unsigned CMAX_W    = 3;
  localparam int unsigned THR_W     = 3;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values
  localparam logic [CMAX_W-1:0] COUNTER_MAX_RST      = 3'd3;
  localparam logic [THR_W-1:0]  TAKEN_THRESHOLD_RST  = 3'd1;
  localparam logic [HIST_W-1:0] HISTORY_MASK_RST     = 10'h3FF;
  localparam logic [HIST_W-1:0] ADDR_INDEX_MASK_RST  = 10'h3FF;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTER_MAX        = 2'd0,
    REG_TAKEN_THRESHOLD    = 2'd1,
    REG_HISTORY_MASK       = 2'd2,
    REG_ADDR_INDEX_MASK    = 2'd3
  } cfg_reg_e;

  // Request operations
  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_TRAIN   = 1'b1
  } op_e;

endpackage

`default_nettype wire

@@ rtl/tlbp_mod.sv @@
`default_nettype none

// Remainder of a narrow value by a constant, one register stage deep.
// Stage one estimates the quotient by a reciprocal multiply; stage two
// takes the remainder and corrects the estimate once.
module tlbp_mod #(
  parameter int unsigned DIVISOR = 2,
  parameter int unsigned IN_W    = 10,
  parameter int unsigned OUT_W   = 1
) (
  input  wire logic             clk_i,
  input  wire logic [IN_W-1:0]  x_i,
  output logic      [OUT_W-1:0] r_o
);

  localparam int unsigned Shift  = 20;
  localparam int unsigned Recip  = (1 << Shift) / DIVISOR;
  localparam int unsigned ProdW  = IN_W + Shift;

  logic [ProdW-1:0] prod;
  logic [IN_W-1:0]  q_d, q_q;
  logic [IN_W-1:0]  x_q;
  logic [31:0]      qd, rem, rem_fix;

  // Estimate the quotient, low by at most one
  assign prod = ProdW'(x_i) * ProdW'(Recip);
  assign q_d  = prod[ProdW-1:Shift];

  always_ff @(posedge clk_i) begin
    x_q <= x_i;
    q_q <= q_d;
  end

  // Take the remainder and correct once
  assign qd      = 32'(q_q) * 32'(DIVISOR);
  assign rem     = 32'(x_q) - qd;
  assign rem_fix = (rem >= 32'(DIVISOR)) ? (rem - 32'(DIVISOR)) : rem;
  assign r_o     = rem_fix[OUT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/tlbp_ram.sv @@
`default_nettype none

// Simple dual-port memory, one write and one registered read per cycle.
module tlbp_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  parameter int unsigned AW    = 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/two_level_local_branch_predictor_top.sv @@
`default_nettype none

// Channel   Handshake                 Payload
// request   start / busy              operation_i, branch_address_i, taken_outcome_i
// result    result_valid_o (strobe)   predicted_taken_o
// config    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A request steps through accept, history read, pattern index, counter
// read and update. The result strobe comes in the cycle where busy drops,
// so the next request can be taken then. The rate is set by the dependent
// reads of the history and counter memories. After reset a clearing pass
// over every entry of both memories holds busy high; configuration writes
// are taken during it.
// The receiver cannot stall: each result is shown for one cycle.
module two_level_local_branch_predictor_top #(
  parameter int unsigned HISTORY_DEPTH = 1024,
  parameter int unsigned PATTERN_DEPTH = 1024,
  parameter int unsigned COUNTER_BITS  = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              operation_i,
  input  wire logic [tlbp_pkg::ADDR_W-1:0]       branch_address_i,
  input  wire logic                              taken_outcome_i,
  output logic                                   result_valid_o,
  output logic                                   predicted_taken_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tlbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tlbp_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned HIW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned PIW   = $clog2(PATTERN_DEPTH);
  localparam int unsigned MaxD  = (HISTORY_DEPTH > PATTERN_DEPTH) ? HISTORY_DEPTH
                                                                  : PATTERN_DEPTH;
  localparam int unsigned ClrW  = $clog2(MaxD);
  localparam int unsigned CW    = (COUNTER_BITS > 3) ? COUNTER_BITS : 3;
  localparam int unsigned CntAllMax = (1 << COUNTER_BITS) - 1;
  localparam int unsigned CntInit   = (CntAllMax < 3) ? CntAllMax : 3;
  localparam int unsigned HW    = tlbp_pkg::HIST_W;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_HRD,
    S_PMOD,
    S_PRD,
    S_UPD
  } state_e;

  state_e state_q;
  logic [ClrW-1:0] clr_q;
  logic            result_valid_q, predicted_q;

  logic [tlbp_pkg::CMAX_W-1:0] cmax_q;
  logic [tlbp_pkg::THR_W-1:0]  thr_q;
  logic [HW-1:0]               hmask_q, amask_q;

  logic            op_q, outcome_q;
  logic [HIW-1:0]  hidx_q, hidx;
  logic [PIW-1:0]  pidx_q, pidx;
  logic [HW-1:0]   hist_q, hist_rdata;
  logic [COUNTER_BITS-1:0] cnt_rdata, cnt_new;

  logic            hist_we, cnt_we, accept, clr_last;
  logic [HIW-1:0]  hist_waddr;
  logic [HW-1:0]   hist_wdata, hist_new;
  logic [PIW-1:0]  cnt_waddr;
  logic [COUNTER_BITS-1:0] cnt_wdata;
  logic [CW-1:0]   cnt_ext, ceil_ext, cmax_ext, thr_ext;
  logic            pred;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign clr_last = (32'(clr_q) == 32'(MaxD - 1));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmax_q  <= tlbp_pkg::COUNTER_MAX_RST;
      thr_q   <= tlbp_pkg::TAKEN_THRESHOLD_RST;
      hmask_q <= tlbp_pkg::HISTORY_MASK_RST;
      amask_q <= tlbp_pkg::ADDR_INDEX_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tlbp_pkg::REG_COUNTER_MAX:     cmax_q  <= cfg_wdata_i[tlbp_pkg::CMAX_W-1:0];
        tlbp_pkg::REG_TAKEN_THRESHOLD: thr_q   <= cfg_wdata_i[tlbp_pkg::THR_W-1:0];
        tlbp_pkg::REG_HISTORY_MASK:    hmask_q <= cfg_wdata_i[HW-1:0];
        tlbp_pkg::REG_ADDR_INDEX_MASK: amask_q <= cfg_wdata_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // Reduce the masked address to a history index
  tlbp_mod #(
    .DIVISOR (HISTORY_DEPTH),
    .IN_W    (HW),
    .OUT_W   (HIW)
  ) u_hmod (
    .clk_i (clk_i),
    .x_i   (branch_address_i[HW-1:0] & amask_q),
    .r_o   (hidx)
  );

  // Reduce the local history to a pattern index
  tlbp_mod #(
    .DIVISOR (PATTERN_DEPTH),
    .IN_W    (HW),
    .OUT_W   (PIW)
  ) u_pmod (
    .clk_i (clk_i),
    .x_i   (hist_rdata),
    .r_o   (pidx)
  );

  tlbp_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (HW),
    .AW    (HIW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hidx),
    .rdata_o (hist_rdata)
  );

  tlbp_ram #(
    .DEPTH (PATTERN_DEPTH),
    .WIDTH (COUNTER_BITS),
    .AW    (PIW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (pidx),
    .rdata_o (cnt_rdata)
  );

  // Predict and saturate the counter
  assign cnt_ext  = CW'(cnt_rdata);
  assign cmax_ext = CW'(cmax_q);
  assign ceil_ext = (cmax_ext > CW'(CntAllMax)) ? CW'(CntAllMax) : cmax_ext;
  assign thr_ext  = CW'(thr_q);
  assign pred     = (cnt_ext > thr_ext);

  always_comb begin
    cnt_new = cnt_rdata;
    if (outcome_q) begin
      if (cnt_ext < ceil_ext) begin
        cnt_new = cnt_rdata + COUNTER_BITS'(1);
      end
    end else if (cnt_rdata != '0) begin
      cnt_new = cnt_rdata - COUNTER_BITS'(1);
    end
  end

  // Shift the outcome into the history
  assign hist_new = {hist_q[HW-2:0], outcome_q} & hmask_q;

  // Select clearing pass or update writes
  always_comb begin
    if (state_q == S_CLR) begin
      hist_we    = (32'(clr_q) < 32'(HISTORY_DEPTH));
      hist_waddr = clr_q[HIW-1:0];
      hist_wdata = '0;
      cnt_we     = (32'(clr_q) < 32'(PATTERN_DEPTH));
      cnt_waddr  = clr_q[PIW-1:0];
      cnt_wdata  = COUNTER_BITS'(CntInit);
    end else begin
      hist_we    = (state_q == S_UPD) && (op_q == tlbp_pkg::OP_TRAIN);
      hist_waddr = hidx_q;
      hist_wdata = hist_new;
      cnt_we     = hist_we;
      cnt_waddr  = pidx_q;
      cnt_wdata  = cnt_new;
    end
  end

  // Hold request payload and indexes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      outcome_q <= taken_outcome_i;
    end
    if (state_q == S_HRD) begin
      hidx_q <= hidx;
    end
    if (state_q == S_PMOD) begin
      hist_q <= hist_rdata;
    end
    if (state_q == S_PRD) begin
      pidx_q <= pidx;
    end
  end

  // Advance the sequencer and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_q          <= '0;
      result_valid_q <= 1'b0;
      predicted_q    <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + ClrW'(1);
          if (clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_HRD;
          end
        end
        S_HRD:  state_q <= S_PMOD;
        S_PMOD: state_q <= S_PRD;
        S_PRD:  state_q <= S_UPD;
        S_UPD: begin
          result_valid_q <= 1'b1;
          predicted_q    <= pred;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o    = result_valid_q;
  assign predicted_taken_o = predicted_q;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == S_UPD)
    else $error("result strobe without an update cycle");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_we || cnt_we) |-> (state_q == S_UPD || state_q == S_CLR))
    else $error("memory write outside update or clearing");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && op_q == tlbp_pkg::OP_TRAIN) |->
      (outcome_q ? (cnt_new >= cnt_rdata) : (cnt_new <= cnt_rdata)))
    else $error("counter moved against the outcome");

  a_hist_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ((hist_new & ~hmask_q) == '0))
    else $error("stored history has bits outside the mask");
`endif

endmodule

`default_nettype wire

@@ tb/two_level_local_branch_predictor_top_tb.sv @@
`timescale 1ns / 1ps

module two_level_local_branch_predictor_top_tb;

  localparam int unsigned HIST_DEPTH  = 1024;
  localparam int unsigned PAT_DEPTH   = 1024;
  localparam int unsigned CTR_BITS    = 3;
  localparam logic [2:0]  CTR_TOP     = 3'((1 << CTR_BITS) - 1);
  localparam int          SETTLE_CYC  = 8;
  localparam int          DRAIN_LIMIT = 200;

  typedef struct {
    tlbp_pkg::op_e op;
    logic [31:0]   addr;
    logic          outcome;
    logic          taken;
  } branch_req_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic                            operation_i;
  logic [tlbp_pkg::ADDR_W-1:0]     branch_address_i;
  logic                            taken_outcome_i;
  logic                            result_valid_o;
  logic                            predicted_taken_o;
  logic                            cfg_we_i;
  logic [tlbp_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [tlbp_pkg::CFG_W-1:0]      cfg_wdata_i;

  // Shadow copy of the predictor state and registers
  logic [tlbp_pkg::HIST_W-1:0]     hist_tbl [HIST_DEPTH];
  logic [CTR_BITS-1:0]             ctr_tbl  [PAT_DEPTH];
  logic [tlbp_pkg::CMAX_W-1:0]     ceil_reg;
  logic [tlbp_pkg::THR_W-1:0]      thr_reg;
  logic [tlbp_pkg::HIST_W-1:0]     hist_mask_reg;
  logic [tlbp_pkg::HIST_W-1:0]     addr_mask_reg;

  branch_req_t           pending_predictions [$];
  int                    mismatch_count;
  int                    result_count;
  int                    request_count;
  int                    train_count;
  int                    settings_count;
  int                    sender_idle_pct;

  two_level_local_branch_predictor_top #(
    .HISTORY_DEPTH (HIST_DEPTH),
    .PATTERN_DEPTH (PAT_DEPTH),
    .COUNTER_BITS  (CTR_BITS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .branch_address_i  (branch_address_i),
    .taken_outcome_i   (taken_outcome_i),
    .result_valid_o    (result_valid_o),
    .predicted_taken_o (predicted_taken_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Compute the prediction from the current state, then apply a train
  function automatic logic compute_prediction(tlbp_pkg::op_e op, logic [31:0] addr,
                                              logic outcome);
    int unsigned                 hidx;
    int unsigned                 pidx;
    logic [tlbp_pkg::HIST_W-1:0] hist;
    logic [2:0]                  cnt;
    logic [2:0]                  ceil_val;
    logic                        taken;
    hidx  = (addr & {22'b0, addr_mask_reg}) % HIST_DEPTH;
    hist  = hist_tbl[hidx];
    pidx  = hist % PAT_DEPTH;
    cnt   = ctr_tbl[pidx];
    taken = (cnt > thr_reg);
    if (op == tlbp_pkg::OP_TRAIN) begin
      ceil_val = (ceil_reg > CTR_TOP) ? CTR_TOP : ceil_reg;
      if (outcome) begin
        if (cnt < ceil_val) cnt = cnt + 3'd1;
      end else begin
        if (cnt > 3'd0) cnt = cnt - 3'd1;
      end
      ctr_tbl[pidx]  = cnt[CTR_BITS-1:0];
      hist_tbl[hidx] = {hist[tlbp_pkg::HIST_W-2:0], outcome} & hist_mask_reg;
    end
    return taken;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one request; hold it until the block takes it, then log the prediction
  task automatic send_request(tlbp_pkg::op_e op, logic [31:0] addr, logic outcome);
    branch_req_t req;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start            <= 1'b1;
    operation_i      <= op;
    branch_address_i <= addr;
    taken_outcome_i  <= outcome;
    do @(posedge clk_i); while (busy);
    req.op      = op;
    req.addr    = addr;
    req.outcome = outcome;
    req.taken   = compute_prediction(op, addr, outcome);
    pending_predictions.push_back(req);
    request_count++;
    if (op == tlbp_pkg::OP_TRAIN) train_count++;
  endtask

  // Drop start and wait until every prediction has come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_predictions.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (pending_predictions.size() != 0) begin
      report_mismatch($sformatf("%0d predictions never arrived", pending_predictions.size()));
      pending_predictions.delete();
    end
  endtask

  // Write all four registers, one per cycle; block must be idle
  task automatic apply_settings(logic [2:0] cmax, logic [2:0] thr,
                                logic [9:0] hmask, logic [9:0] amask);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= tlbp_pkg::REG_COUNTER_MAX;
    cfg_wdata_i <= {7'b0, cmax};
    @(negedge clk_i);
    cfg_index_i <= tlbp_pkg::REG_TAKEN_THRESHOLD;
    cfg_wdata_i <= {7'b0, thr};
    @(negedge clk_i);
    cfg_index_i <= tlbp_pkg::REG_HISTORY_MASK;
    cfg_wdata_i <= hmask;
    @(negedge clk_i);
    cfg_index_i <= tlbp_pkg::REG_ADDR_INDEX_MASK;
    cfg_wdata_i <= amask;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ceil_reg      = cmax;
    thr_reg       = thr;
    hist_mask_reg = hmask;
    addr_mask_reg = amask;
    settings_count++;
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin
    branch_req_t req;
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (pending_predictions.size() == 0) begin
        report_mismatch($sformatf("result %0b with no request outstanding",
                                  predicted_taken_o));
      end else begin
        req = pending_predictions.pop_front();
        if (predicted_taken_o !== req.taken)
          report_mismatch($sformatf("%s addr %08h outcome %0b: taken %b, expected %b",
                                    req.op.name(), req.addr, req.outcome,
                                    predicted_taken_o, req.taken));
      end
    end
  end

  // Fresh counters predict taken; predicts must not disturb the state
  task automatic test_reset_state();
    send_request(tlbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b1);
    send_request(tlbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
    send_request(tlbp_pkg::OP_TRAIN,   32'hFFFF_FFFF, 1'b1);
    send_request(tlbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
    wait_idle();
  endtask

  // Pin the history to zero and walk one counter to both rails
  task automatic test_counter_saturation();
    apply_settings(3'd7, 3'd0, 10'h000, 10'h3FF);
    repeat (5) send_request(tlbp_pkg::OP_TRAIN, 32'h0000_0005, 1'b1);
    wait_idle();
    // lower the ceiling below the counter: no raise, still falls
    apply_settings(3'd2, 3'd0, 10'h000, 10'h3FF);
    send_request(tlbp_pkg::OP_TRAIN, 32'h0000_0005, 1'b1);
    repeat (8) send_request(tlbp_pkg::OP_TRAIN, 32'h0000_0005, 1'b0);
    wait_idle();
  endtask

  // Zero ceiling holds a zero counter; top threshold never predicts taken
  task automatic test_zero_ceiling();
    apply_settings(3'd0, 3'd7, 10'h000, 10'h3FF);
    send_request(tlbp_pkg::OP_TRAIN,   32'h0000_0005, 1'b1);
    send_request(tlbp_pkg::OP_PREDICT, 32'h0000_0005, 1'b1);
    wait_idle();
  endtask

  // Zero index mask folds every address onto one history
  task automatic test_address_aliasing();
    apply_settings(3'd3, 3'd1, 10'h3FF, 10'h000);
    send_request(tlbp_pkg::OP_TRAIN,   32'h1234_5678, 1'b1);
    send_request(tlbp_pkg::OP_TRAIN,   32'hFFFF_F000, 1'b0);
    send_request(tlbp_pkg::OP_PREDICT, 32'h8000_0001, 1'b0);
    wait_idle();
  endtask

  // Mostly patterned branches on a few hot addresses, plus random noise
  task automatic test_random_traffic(int n_items, int idle_pct);
    logic [31:0]   hot_addr [8];
    logic [7:0]    pattern  [8];
    int            pos      [8];
    int            k;
    logic [31:0]   addr;
    logic          outcome;
    tlbp_pkg::op_e op;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < 8; i++) begin
      hot_addr[i] = $urandom;
      pattern[i]  = 8'($urandom);
      pos[i]      = 0;
    end
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        k       = $urandom_range(0, 7);
        addr    = hot_addr[k];
        outcome = pattern[k][pos[k] % 8];
        pos[k]++;
        if ($urandom_range(0, 9) == 0) outcome = ~outcome;
        op = ($urandom_range(0, 4) != 0) ? tlbp_pkg::OP_TRAIN : tlbp_pkg::OP_PREDICT;
      end else begin
        addr    = $urandom;
        outcome = 1'($urandom);
        op      = tlbp_pkg::op_e'($urandom_range(0, 1));
      end
      send_request(op, addr, outcome);
    end
    wait_idle();
  endtask

  initial begin
    start            <= 1'b0;
    operation_i      <= 1'b0;
    branch_address_i <= '0;
    taken_outcome_i  <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= tlbp_pkg::REG_COUNTER_MAX;
    cfg_wdata_i      <= '0;
    rst_ni           <= 1'b0;
    mismatch_count  = 0;
    result_count    = 0;
    request_count   = 0;
    train_count     = 0;
    settings_count  = 0;
    sender_idle_pct = 13;
    ceil_reg      = tlbp_pkg::COUNTER_MAX_RST;
    thr_reg       = tlbp_pkg::TAKEN_THRESHOLD_RST;
    hist_mask_reg = tlbp_pkg::HISTORY_MASK_RST;
    addr_mask_reg = tlbp_pkg::ADDR_INDEX_MASK_RST;
    for (int i = 0; i < HIST_DEPTH; i++) hist_tbl[i] = '0;
    for (int i = 0; i < PAT_DEPTH; i++)  ctr_tbl[i]  = tlbp_pkg::COUNTER_MAX_RST;

    // Hold reset, then let the clearing pass finish
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);

    test_reset_state();
    test_counter_saturation();
    test_zero_ceiling();
    test_address_aliasing();

    apply_settings(3'd7, 3'd3, 10'h3FF, 10'h3FF);
    test_random_traffic(200, 13);
    apply_settings(3'd1, 3'd0, 10'h01F, 10'h00F);
    test_random_traffic(200, 50);
    apply_settings(3'($urandom_range(1, 7)), 3'($urandom), 10'($urandom), 10'($urandom));
    test_random_traffic(200, 0);

    $display("Covered %0d requests (%0d trains), %0d results, %0d register settings",
             request_count, train_count, result_count, settings_count);
    $display("Counter rails, lowered and zero ceilings, address aliasing, random traffic");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
